@@ hdl/rfbe_pkg.sv @@
package rfbe_pkg;

  localparam int CRD_W   = 20;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 2;
  localparam int PIX_W   = 32;
  localparam int EXT_W   = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  typedef enum logic [1:0] {
    REQ_FILL = 2'd0,
    REQ_BLIT = 2'd1,
    REQ_READ = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CLIP_SRC,
    ST_CLIP_DST,
    ST_LIM_SRC,
    ST_LIM_DST,
    ST_PLAN,
    ST_ADDR,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [PIX_W-1:0] read_pixel;
    logic             clipped_empty;
  } res_t;

endpackage

@@ hdl/rfbe_if.sv @@
interface rfbe_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [15:0] dst_x;
  logic signed [15:0] dst_y;
  logic signed [15:0] src_x;
  logic signed [15:0] src_y;
  logic signed [15:0] rect_w;
  logic signed [15:0] rect_h;
  logic [31:0]        fill_color;

  modport source (output valid, req_type, dst_x, dst_y, src_x, src_y, rect_w, rect_h,
                  fill_color, input ready);
  modport sink (input valid, req_type, dst_x, dst_y, src_x, src_y, rect_w, rect_h,
                fill_color, output ready);
endinterface

interface rfbe_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_pixel;
  logic        clipped_empty;

  modport source (output valid, read_pixel, clipped_empty, input ready);
  modport sink (input valid, read_pixel, clipped_empty, output ready);
endinterface

@@ hdl/rect_fill_and_blit_engine_core.sv @@
// Channel   Dir  Payload
// req_i     in   req_type, dst_x, dst_y, src_x, src_y, rect_w, rect_h, fill_color
// rsp_o     out  read_pixel, clipped_empty
// cfg_*     in   write enable, register index, 7-bit data (no handshake)
//
// After reset the frame store is zeroed, all MAX_WIDTH*MAX_HEIGHT words,
// during which no request is taken; configuration writes are taken throughout.
// A request passes through clipping, limiting, planning and address setup,
// then walks one clipped pixel per cycle on the store's single read and single
// write port, then drains and responds; an empty rectangle skips the walk and
// the unused request code goes straight to the response.
// A result waits in the output register; the next request is taken meanwhile,
// and its result is held back until the register is free.
module rect_fill_and_blit_engine_core #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rfbe_req_if.sink                       req_i,
  rfbe_rsp_if.source                     rsp_o,
  input  logic                           cfg_we_i,
  input  logic [rfbe_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rfbe_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import rfbe_pkg::*;

  localparam int XW    = $clog2(MAX_WIDTH + 1);
  localparam int YW    = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CFG_W-1:0] cfg_w_q, cfg_h_q;
  logic [XW-1:0]    sw;
  logic [YW-1:0]    sh;
  logic             out_valid_q, res_valid, res_free;
  res_t             res, out_q;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [PIX_W-1:0] mem_wdata, mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= CFG_W'(64);
      cfg_h_q <= CFG_W'(64);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_WIDTH) cfg_w_q <= cfg_wdata_i;
      if (cfg_idx_i == CFG_HEIGHT) cfg_h_q <= cfg_wdata_i;
    end
  end

  assign sw = (EXT_W'(cfg_w_q) > EXT_W'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(cfg_w_q);
  assign sh = (EXT_W'(cfg_h_q) > EXT_W'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) : YW'(cfg_h_q);

  assign res_free = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_free && res_valid) out_q <= res;
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.read_pixel = out_q.read_pixel;
  assign rsp_o.clipped_empty = out_q.clipped_empty;

  rfbe_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .XW         (XW),
    .YW         (YW),
    .DEPTH      (DEPTH),
    .AW         (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sw_i        (sw),
    .sh_i        (sh),
    .req_i       (req_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_free_i  (res_free)
  );

  rfbe_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

@@ hdl/rfbe_store.sv @@
module rfbe_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AW-1:0]           waddr_i,
  input  logic [rfbe_pkg::PIX_W-1:0] wdata_i,
  input  logic [AW-1:0]           raddr_i,
  output logic [rfbe_pkg::PIX_W-1:0] rdata_o
);
  import rfbe_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/rfbe_ctrl.sv @@
module rfbe_ctrl #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int XW         = 7,
  parameter int YW         = 7,
  parameter int DEPTH      = 4096,
  parameter int AW         = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [XW-1:0]              sw_i,
  input  logic [YW-1:0]              sh_i,
  rfbe_req_if.sink                   req_i,
  output logic                       mem_we_o,
  output logic [AW-1:0]              mem_waddr_o,
  output logic [rfbe_pkg::PIX_W-1:0] mem_wdata_o,
  output logic [AW-1:0]              mem_raddr_o,
  input  logic [rfbe_pkg::PIX_W-1:0] mem_rdata_i,
  output logic                       res_valid_o,
  output rfbe_pkg::res_t             res_o,
  input  logic                       res_free_i
);
  import rfbe_pkg::*;

  localparam int PW = XW + YW + 1;

  state_e state_q, state_d;

  logic signed [CRD_W-1:0] sx_q, sy_q, dx_q, dy_q, w_q, h_q;
  logic signed [CRD_W-1:0] swc, shc;
  req_e                    kind_q;
  logic [PIX_W-1:0]        color_q, pix_q;
  logic                    empty_q, back_q, pend_q;
  logic [AW-1:0]           clr_q, daddr_q, saddr_q, pend_addr_q, step;
  logic [YW-1:0]           drow_q, srow_q, row_q;
  logic [XW-1:0]           dcol_q, scol_q, col_q, wn_q, gap_q;
  logic [PW-1:0]           dprod, sprod;
  logic                    is_empty, last_px;

  assign swc = CRD_W'(sw_i);
  assign shc = CRD_W'(sh_i);
  assign is_empty = (w_q <= 0) || (h_q <= 0);
  assign last_px = (col_q == XW'(1)) && (row_q == YW'(1));
  assign dprod = PW'(drow_q) * PW'(sw_i) + PW'(dcol_q);
  assign sprod = PW'(srow_q) * PW'(sw_i) + PW'(scol_q);
  assign step = (col_q == XW'(1)) ? AW'(gap_q) + AW'(1) : AW'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:    if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (req_i.valid) begin
          state_d = (req_e'(req_i.req_type) == REQ_NONE) ? ST_DONE : ST_CLIP_SRC;
        end
      end
      ST_CLIP_SRC: state_d = ST_CLIP_DST;
      ST_CLIP_DST: state_d = ST_LIM_SRC;
      ST_LIM_SRC:  state_d = ST_LIM_DST;
      ST_LIM_DST:  state_d = ST_PLAN;
      ST_PLAN:     state_d = is_empty ? ST_DONE : ST_ADDR;
      ST_ADDR:     state_d = ST_RUN;
      ST_RUN:      if (last_px) state_d = ST_DRAIN;
      ST_DRAIN:    state_d = ST_DONE;
      ST_DONE:     if (res_free_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready = (state_q == ST_IDLE);
    res_valid_o = (state_q == ST_DONE);
    res_o.read_pixel = pix_q;
    res_o.clipped_empty = empty_q;
    mem_raddr_o = (kind_q == REQ_READ) ? daddr_q : saddr_q;
    mem_we_o = 1'b0;
    mem_waddr_o = pend_addr_q;
    mem_wdata_o = mem_rdata_i;
    if (state_q == ST_CLEAR) begin
      mem_we_o = 1'b1;
      mem_waddr_o = clr_q;
      mem_wdata_o = '0;
    end else if (state_q == ST_RUN && kind_q == REQ_FILL) begin
      mem_we_o = 1'b1;
      mem_waddr_o = daddr_q;
      mem_wdata_o = color_q;
    end else if (pend_q) begin
      mem_we_o = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q <= '0;
      pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      pend_q <= (state_q == ST_RUN) && (kind_q == REQ_BLIT);
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= daddr_q;
    case (state_q)
      ST_IDLE: begin
        kind_q <= req_e'(req_i.req_type);
        color_q <= req_i.fill_color;
        empty_q <= 1'b0;
        pix_q <= '0;
        dx_q <= CRD_W'(req_i.dst_x);
        dy_q <= CRD_W'(req_i.dst_y);
        if (req_e'(req_i.req_type) == REQ_BLIT) begin
          sx_q <= CRD_W'(req_i.src_x);
          sy_q <= CRD_W'(req_i.src_y);
        end else begin
          sx_q <= CRD_W'(req_i.dst_x);
          sy_q <= CRD_W'(req_i.dst_y);
        end
        if (req_e'(req_i.req_type) == REQ_READ) begin
          w_q <= CRD_W'(1);
          h_q <= CRD_W'(1);
        end else begin
          w_q <= CRD_W'(req_i.rect_w);
          h_q <= CRD_W'(req_i.rect_h);
        end
      end
      ST_CLIP_SRC: begin
        if (sx_q < 0) begin
          w_q <= w_q + sx_q;
          dx_q <= dx_q - sx_q;
          sx_q <= '0;
        end
        if (sy_q < 0) begin
          h_q <= h_q + sy_q;
          dy_q <= dy_q - sy_q;
          sy_q <= '0;
        end
      end
      ST_CLIP_DST: begin
        if (dx_q < 0) begin
          w_q <= w_q + dx_q;
          sx_q <= sx_q - dx_q;
          dx_q <= '0;
        end
        if (dy_q < 0) begin
          h_q <= h_q + dy_q;
          sy_q <= sy_q - dy_q;
          dy_q <= '0;
        end
      end
      ST_LIM_SRC: begin
        if (sx_q + w_q > swc) w_q <= swc - sx_q;
        if (sy_q + h_q > shc) h_q <= shc - sy_q;
      end
      ST_LIM_DST: begin
        if (dx_q + w_q > swc) w_q <= swc - dx_q;
        if (dy_q + h_q > shc) h_q <= shc - dy_q;
      end
      ST_PLAN: begin
        empty_q <= is_empty;
        back_q <= (dy_q > sy_q) || ((dy_q == sy_q) && (dx_q > sx_q));
        wn_q <= XW'(w_q);
        col_q <= XW'(w_q);
        row_q <= YW'(h_q);
        gap_q <= XW'(swc - w_q);
        if ((dy_q > sy_q) || ((dy_q == sy_q) && (dx_q > sx_q))) begin
          drow_q <= YW'(dy_q + h_q - CRD_W'(1));
          srow_q <= YW'(sy_q + h_q - CRD_W'(1));
          dcol_q <= XW'(dx_q + w_q - CRD_W'(1));
          scol_q <= XW'(sx_q + w_q - CRD_W'(1));
        end else begin
          drow_q <= YW'(dy_q);
          srow_q <= YW'(sy_q);
          dcol_q <= XW'(dx_q);
          scol_q <= XW'(sx_q);
        end
      end
      ST_ADDR: begin
        daddr_q <= AW'(dprod);
        saddr_q <= AW'(sprod);
      end
      ST_RUN: begin
        if (col_q == XW'(1)) begin
          col_q <= wn_q;
          row_q <= row_q - YW'(1);
        end else begin
          col_q <= col_q - XW'(1);
        end
        if (back_q) begin
          daddr_q <= daddr_q - step;
          saddr_q <= saddr_q - step;
        end else begin
          daddr_q <= daddr_q + step;
          saddr_q <= saddr_q + step;
        end
      end
      ST_DRAIN: begin
        if (kind_q == REQ_READ) pix_q <= mem_rdata_i;
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_pend_blit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> kind_q == REQ_BLIT)
    else $error("pending copy write outside a blit");
  a_run_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> (col_q != '0) && (row_q != '0))
    else $error("pixel walk with an exhausted counter");
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !pend_q && !mem_we_o)
    else $error("store written while idle");
  a_run_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && last_px) |=> state_q == ST_DRAIN)
    else $error("walk did not end after its last pixel");
`endif

endmodule
